>>> hdl/bwtenc_pkg.sv
// ----------------------------------------------------------------------------
// bwtenc_pkg
// Shared types and constants of the block Burrows-Wheeler encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bwtenc_pkg;

	// Largest block, and the widths that follow from it.
	localparam int BLOCK = 1024;
	localparam int IDX_W = $clog2(BLOCK);
	localparam int LEN_W = IDX_W + 1;
	localparam int EXT_W = LEN_W + 1;

	// Command queue between the front and the engine.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_PULL = 1'b1
	} cmd_t;

	// One queued transaction.
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] data;
		logic       eob;
	} qentry_t;

endpackage

>>> hdl/bwtenc_front.sv
// ----------------------------------------------------------------------------
// bwtenc_front
// Accepts input transactions, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bwtenc_front import bwtenc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       command,
	input  logic [7:0] data_byte,
	input  logic       end_of_block,
	input  logic       pop,
	output logic       nonempty,
	output qentry_t    head
);

	qentry_t             queue_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	logic                push_en;
	qentry_t             entry;

	// Classify the incoming transaction.
	always_comb begin
		entry.cmd  = command ? CMD_PULL : CMD_PUSH;
		entry.data = data_byte;
		entry.eob  = end_of_block;
	end

	assign in_stall = (count_q == (QPTR_W+1)'(QDEPTH));
	assign push_en  = in_valid && !in_stall;
	assign nonempty = (count_q != '0);
	assign head     = queue_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push_en) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push_en && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/bwtenc_engine.sv
// ----------------------------------------------------------------------------
// bwtenc_engine
// Loads the block, sorts its rotations by merge sort and serves pulls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bwtenc_engine import bwtenc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             nonempty,
	input  qentry_t          head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       bwt_byte,
	output logic [IDX_W-1:0] primary_index,
	output logic             last_of_block,
	output logic             status
);

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_SEG, S_FETCH, S_COPYP, S_COPYQ, S_CMP0, S_CMP,
		S_FIND_RD, S_FIND_CHK, S_PULL1, S_PULL2
	} state_t;

	state_t            state_q;
	logic              unload_q;
	logic              sel_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  n_q;
	logic [LEN_W-1:0]  rp_q;
	logic [IDX_W-1:0]  origin_q;
	logic [LEN_W-1:0]  width_q;
	logic [EXT_W-1:0]  lo_q;
	logic [LEN_W-1:0]  mid_q;
	logic [LEN_W-1:0]  hi_q;
	logic [LEN_W-1:0]  p_q;
	logic [LEN_W-1:0]  q_q;
	logic [LEN_W-1:0]  o_q;
	logic [LEN_W-1:0]  k_q;
	logic [IDX_W-1:0]  px_q;
	logic [IDX_W-1:0]  py_q;
	logic [IDX_W-1:0]  ip_q;
	logic [IDX_W-1:0]  iq_q;

	// Memories: block bytes and two buffers of rotation indices.
	logic [7:0]        store_mem [BLOCK];
	logic [IDX_W-1:0]  idx0_mem [BLOCK];
	logic [IDX_W-1:0]  idx1_mem [BLOCK];
	logic [7:0]        sx_q;
	logic [7:0]        sy_q;
	logic [IDX_W-1:0]  r0a_q, r0b_q, r1a_q, r1b_q;
	logic [IDX_W-1:0]  ra;
	logic [IDX_W-1:0]  rb;

	logic [IDX_W-1:0]  addr_a, addr_b, addr_x, addr_y;
	logic              iw_en;
	logic              iw_sel;
	logic [IDX_W-1:0]  iw_addr;
	logic [IDX_W-1:0]  iw_data;
	logic              sw_en;
	logic              out_free;
	logic              take;
	logic [LEN_W-1:0]  px_inc, py_inc;
	logic [IDX_W-1:0]  px_next, py_next;
	logic [IDX_W-1:0]  prev;
	logic [EXT_W-1:0]  lo_w, lo_2w, width_2;
	logic              q_first;

	assign ra = sel_q ? r1a_q : r0a_q;
	assign rb = sel_q ? r1b_q : r0b_q;

	assign out_free = !out_valid || !out_stall;
	assign take     = (state_q == S_IDLE) && nonempty && out_free;
	assign pop      = take;

	// Wrapping advance of the two rotation pointers.
	assign px_inc  = LEN_W'(px_q) + 1'b1;
	assign py_inc  = LEN_W'(py_q) + 1'b1;
	assign px_next = (px_inc == n_q) ? '0 : px_inc[IDX_W-1:0];
	assign py_next = (py_inc == n_q) ? '0 : py_inc[IDX_W-1:0];
	assign prev    = (ra == '0) ? IDX_W'(n_q - 1'b1) : ra - 1'b1;

	assign lo_w    = lo_q + EXT_W'(width_q);
	assign lo_2w   = lo_w + EXT_W'(width_q);
	assign width_2 = {width_q, 1'b0};

	// Rotation q precedes rotation p when its bytes are smaller, or on a tie
	// when its start index is larger.
	assign q_first = (sx_q != sy_q) ? (sx_q < sy_q) : (iq_q > ip_q);

	// Memory address and write selection.
	always_comb begin
		addr_a  = p_q[IDX_W-1:0];
		addr_b  = q_q[IDX_W-1:0];
		addr_x  = px_next;
		addr_y  = py_next;
		iw_en   = 1'b0;
		iw_sel  = !sel_q;
		iw_addr = o_q[IDX_W-1:0];
		iw_data = ra;
		sw_en   = take && (head.cmd == CMD_PUSH) && !unload_q;
		unique case (state_q)
			S_INIT: begin
				iw_en   = 1'b1;
				iw_sel  = sel_q;
				iw_data = o_q[IDX_W-1:0];
			end
			S_COPYP: begin
				iw_en = 1'b1;
			end
			S_COPYQ: begin
				iw_en   = 1'b1;
				iw_data = rb;
			end
			S_CMP0: begin
				addr_x = rb;
				addr_y = ra;
			end
			S_CMP: begin
				iw_en   = (sx_q != sy_q) || (k_q == n_q - 1'b1);
				iw_data = q_first ? iq_q : ip_q;
			end
			S_FIND_RD: begin
				addr_a = o_q[IDX_W-1:0];
			end
			S_IDLE: begin
				addr_a = rp_q[IDX_W-1:0];
			end
			S_PULL1: begin
				addr_x = prev;
			end
			default: begin
			end
		endcase
	end

	// Block byte store, two registered read ports.
	always_ff @(posedge clk) begin
		if (sw_en) begin
			store_mem[len_q[IDX_W-1:0]] <= head.data;
		end
		sx_q <= store_mem[addr_x];
		sy_q <= store_mem[addr_y];
	end

	// Rotation index buffers, two registered read ports each.
	always_ff @(posedge clk) begin
		if (iw_en && !iw_sel) begin
			idx0_mem[iw_addr] <= iw_data;
		end
		if (iw_en && iw_sel) begin
			idx1_mem[iw_addr] <= iw_data;
		end
		r0a_q <= idx0_mem[addr_a];
		r0b_q <= idx0_mem[addr_b];
		r1a_q <= idx1_mem[addr_a];
		r1b_q <= idx1_mem[addr_b];
	end

	// Sequencer for load, sort and unload, with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			unload_q      <= 1'b0;
			sel_q         <= 1'b0;
			len_q         <= '0;
			n_q           <= '0;
			rp_q          <= '0;
			origin_q      <= '0;
			width_q       <= '0;
			lo_q          <= '0;
			mid_q         <= '0;
			hi_q          <= '0;
			p_q           <= '0;
			q_q           <= '0;
			o_q           <= '0;
			k_q           <= '0;
			px_q          <= '0;
			py_q          <= '0;
			ip_q          <= '0;
			iq_q          <= '0;
			out_valid     <= 1'b0;
			bwt_byte      <= '0;
			primary_index <= '0;
			last_of_block <= 1'b0;
			status        <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						if (head.cmd == CMD_PULL) begin
							if (unload_q) begin
								state_q <= S_PULL1;
							end else begin
								out_valid     <= 1'b1;
								bwt_byte      <= '0;
								primary_index <= '0;
								last_of_block <= 1'b0;
								status        <= 1'b1;
							end
						end else if (!unload_q) begin
							len_q <= len_q + 1'b1;
							if (head.eob || (len_q + 1'b1 == LEN_W'(BLOCK))) begin
								n_q     <= len_q + 1'b1;
								o_q     <= '0;
								width_q <= LEN_W'(1);
								lo_q    <= '0;
								sel_q   <= 1'b0;
								state_q <= S_INIT;
							end
						end
					end
				end
				S_INIT: begin
					o_q <= o_q + 1'b1;
					if (o_q == n_q - 1'b1) begin
						o_q <= '0;
						state_q <= (n_q == LEN_W'(1)) ? S_FIND_RD : S_SEG;
					end
				end
				S_SEG: begin
					if (lo_q >= EXT_W'(n_q)) begin
						sel_q <= !sel_q;
						lo_q  <= '0;
						if (width_2 >= EXT_W'(n_q)) begin
							o_q     <= '0;
							state_q <= S_FIND_RD;
						end else begin
							width_q <= width_2[LEN_W-1:0];
						end
					end else begin
						mid_q   <= (lo_w > EXT_W'(n_q)) ? n_q : lo_w[LEN_W-1:0];
						hi_q    <= (lo_2w > EXT_W'(n_q)) ? n_q : lo_2w[LEN_W-1:0];
						p_q     <= lo_q[LEN_W-1:0];
						q_q     <= (lo_w > EXT_W'(n_q)) ? n_q : lo_w[LEN_W-1:0];
						o_q     <= lo_q[LEN_W-1:0];
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					priority if (p_q < mid_q && q_q < hi_q) begin
						state_q <= S_CMP0;
					end else if (p_q < mid_q) begin
						state_q <= S_COPYP;
					end else if (q_q < hi_q) begin
						state_q <= S_COPYQ;
					end else begin
						lo_q    <= lo_2w;
						state_q <= S_SEG;
					end
				end
				S_COPYP: begin
					p_q     <= p_q + 1'b1;
					o_q     <= o_q + 1'b1;
					state_q <= S_FETCH;
				end
				S_COPYQ: begin
					q_q     <= q_q + 1'b1;
					o_q     <= o_q + 1'b1;
					state_q <= S_FETCH;
				end
				S_CMP0: begin
					ip_q    <= ra;
					iq_q    <= rb;
					px_q    <= rb;
					py_q    <= ra;
					k_q     <= '0;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if ((sx_q != sy_q) || (k_q == n_q - 1'b1)) begin
						if (q_first) begin
							q_q <= q_q + 1'b1;
						end else begin
							p_q <= p_q + 1'b1;
						end
						o_q     <= o_q + 1'b1;
						state_q <= S_FETCH;
					end else begin
						px_q <= px_next;
						py_q <= py_next;
						k_q  <= k_q + 1'b1;
					end
				end
				S_FIND_RD: begin
					state_q <= S_FIND_CHK;
				end
				S_FIND_CHK: begin
					if (ra == '0) begin
						origin_q <= o_q[IDX_W-1:0];
					end
					if (o_q == n_q - 1'b1) begin
						unload_q <= 1'b1;
						rp_q     <= '0;
						state_q  <= S_IDLE;
					end else begin
						o_q     <= o_q + 1'b1;
						state_q <= S_FIND_RD;
					end
				end
				S_PULL1: begin
					state_q <= S_PULL2;
				end
				S_PULL2: begin
					out_valid     <= 1'b1;
					bwt_byte      <= sx_q;
					primary_index <= origin_q;
					last_of_block <= (rp_q + 1'b1 == len_q);
					status        <= 1'b0;
					if (rp_q + 1'b1 == len_q) begin
						unload_q <= 1'b0;
						len_q    <= '0;
						rp_q     <= '0;
					end else begin
						rp_q <= rp_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/bwt_block_encoder_unit.sv
// ----------------------------------------------------------------------------
// bwt_block_encoder_unit
// Block Burrows-Wheeler encoder: push bytes, then pull the transformed block.
// ----------------------------------------------------------------------------
// A pull passes through an index read, a byte read and the output register.
// After the last byte of a block the engine sorts all rotations with a merge
// sort over two index memories: about log2(n) passes of n merge steps, where
// each comparison walks the block byte store one byte per cycle until the
// rotations differ or all n bytes have matched. Before the sort the engine
// sets up the index buffer, and after it scans the sorted indices to locate
// the primary index. A four-entry command queue decouples the input port
// from the engine.
`timescale 1ns / 1ps

module bwt_block_encoder_unit import bwtenc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             command,
	input  logic [7:0]       data_byte,
	input  logic             end_of_block,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       bwt_byte,
	output logic [IDX_W-1:0] primary_index,
	output logic             last_of_block,
	output logic             status
);

	logic    pop;
	logic    nonempty;
	qentry_t head;

	// Input side and command queue.
	bwtenc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.data_byte    (data_byte),
		.end_of_block (end_of_block),
		.pop          (pop),
		.nonempty     (nonempty),
		.head         (head)
	);

	// Load, sort and unload engine.
	bwtenc_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.nonempty      (nonempty),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.bwt_byte      (bwt_byte),
		.primary_index (primary_index),
		.last_of_block (last_of_block),
		.status        (status)
	);

endmodule
